// ===== rtl/tss_pkg.sv =====
// Package with the types, codes and constants of the transmit slot scheduler.
`default_nettype none
package tss_pkg;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS = 16;
    localparam int KW = $clog2(MAX_RESULTS + 1);
    localparam logic [15:0] HOLD_RESET = 16'd300;
    localparam logic [15:0] STOP_RESET = 16'd300;

    localparam logic       KIND_SERVICE = 1'b1;
    localparam logic [1:0] CMD_VIBRATE = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd3;

    localparam logic [1:0] RK_STATUS = 2'd0;
    localparam logic [1:0] RK_PAYLOAD = 2'd1;
    localparam logic [1:0] RK_TERM = 2'd2;

    localparam logic [2:0] ST_ADDED = 3'd0;
    localparam logic [2:0] ST_UPDATED = 3'd1;
    localparam logic [2:0] ST_ESTOP = 3'd2;
    localparam logic [2:0] ST_UNENC = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;
    localparam logic [2:0] ST_UPD_FAIL = 3'd5;

    localparam logic [7:0] CFG_HOLD = 8'd0;
    localparam logic [7:0] CFG_STOP = 8'd1;

    typedef struct packed {
        logic [2:0]  model;
        logic [15:0] target;
        logic [1:0]  cmd;
        logic [7:0]  inten;
        logic [31:0] end_t;
    } t_entry;

    typedef struct packed {
        logic latch;
        logic svc_start;
        logic rd;
        logic rd_next;
        logic upd;
        logic rm_start;
        logic rm_copy;
        logic cnt_dec;
        logic idx_inc;
        logic resp;
        logic resp_estop;
        logic svc_eval;
        logic push;
        logic svc_done;
    } t_cmd;

    typedef struct packed {
        logic is_svc;
        logic estop;
        logic over;
        logic enc;
        logic cnt_zero;
        logic match;
        logic idx_last;
        logic rm_more;
        logic svc_wait;
        logic idx_end_next;
        logic pend_v;
        logic out_free;
    } t_sts;
endpackage
`default_nettype wire

// ===== rtl/tss_ctrl.sv =====
// Controller state machine that sequences commands, removals and service rounds.
`default_nettype none
module tss_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_busy,
    input  tss_pkg::t_sts   i_sts,
    output tss_pkg::t_cmd   o_cmd
);
    import tss_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_CRD   = 4'd2;
    localparam logic [3:0] S_CCHK  = 4'd3;
    localparam logic [3:0] S_RMRD  = 4'd4;
    localparam logic [3:0] S_RMWR  = 4'd5;
    localparam logic [3:0] S_CNOM  = 4'd6;
    localparam logic [3:0] S_RESP  = 4'd7;
    localparam logic [3:0] S_SRD   = 4'd8;
    localparam logic [3:0] S_SCHK  = 4'd9;
    localparam logic [3:0] S_SDONE = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_sts.is_svc) begin
                    o_cmd.svc_start = 1'b1;
                    n_state = i_sts.cnt_zero ? S_IDLE : S_SRD;
                end else if (i_sts.estop) begin
                    o_cmd.resp_estop = 1'b1;
                    n_state = S_RESP;
                end else if (i_sts.over && !i_sts.cnt_zero) begin
                    n_state = S_CRD;
                end else begin
                    n_state = S_CNOM;
                end
            end
            S_CRD: begin
                o_cmd.rd = 1'b1;
                n_state = S_CCHK;
            end
            S_CCHK: begin
                if (i_sts.match) begin
                    if (i_sts.enc) begin
                        o_cmd.upd = 1'b1;
                        n_state = S_RESP;
                    end else begin
                        o_cmd.rm_start = 1'b1;
                        if (i_sts.idx_last) begin
                            o_cmd.cnt_dec = 1'b1;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_RMRD;
                        end
                    end
                end else if (i_sts.idx_last) begin
                    n_state = S_CNOM;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_CRD;
                end
            end
            S_RMRD: begin
                o_cmd.rd_next = 1'b1;
                n_state = S_RMWR;
            end
            S_RMWR: begin
                o_cmd.rm_copy = 1'b1;
                if (i_sts.rm_more) begin
                    n_state = S_RMRD;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_CNOM: begin
                o_cmd.resp = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SRD: begin
                o_cmd.rd = 1'b1;
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (!i_sts.svc_wait) begin
                    o_cmd.svc_eval = 1'b1;
                    n_state = i_sts.idx_end_next ? S_SDONE : S_SRD;
                end
            end
            S_SDONE: begin
                if (!i_sts.pend_v) begin
                    o_cmd.svc_done = 1'b1;
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.svc_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tss_dp.sv =====
// Datapath with the slot table memory, configuration, pending result and output register.
`default_nettype none
module tss_dp #(
    parameter int DEPTH = tss_pkg::TABLE_DEPTH_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_kind,
    input  wire [2:0]       i_model,
    input  wire [15:0]      i_target_id,
    input  wire [1:0]       i_command_type,
    input  wire [7:0]       i_intensity,
    input  wire [15:0]      i_duration_ms,
    input  wire             i_overwrite,
    input  wire             i_encodable,
    input  wire [31:0]      i_now_ms,
    input  wire             i_estop,
    input  wire             i_cfg_valid,
    input  wire [7:0]       i_cfg_index,
    input  wire [15:0]      i_cfg_data,
    input  tss_pkg::t_cmd   i_cmd,
    output tss_pkg::t_sts   o_sts,
    input  wire             i_out_stall,
    output logic            o_out_valid,
    output logic [1:0]      o_result_kind,
    output logic [2:0]      o_status,
    output logic [3:0]      o_slot,
    output logic [2:0]      o_slot_model,
    output logic [15:0]     o_slot_target,
    output logic [1:0]      o_slot_command,
    output logic [7:0]      o_slot_intensity,
    output logic            o_last
);
    import tss_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [15:0]   r_hold;
    logic [15:0]   r_stop;
    logic          r_was_stopped;
    logic          r_rise;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_w;
    logic [KW-1:0] r_k;
    logic          r_pend_v;
    logic          r_ov;

    logic          r_kind;
    logic [2:0]    r_model;
    logic [15:0]   r_target;
    logic [1:0]    r_cmdt;
    logic [7:0]    r_inten;
    logic [31:0]   r_end;
    logic          r_over;
    logic          r_enc;
    logic [31:0]   r_now;
    logic          r_estop;

    logic [1:0]    r_p_kind;
    logic [2:0]    r_p_status;
    logic [3:0]    r_p_slot;
    logic [2:0]    r_p_model;
    logic [15:0]   r_p_target;
    logic [1:0]    r_p_cmd;
    logic [7:0]    r_p_inten;

    t_entry        r_mem [DEPTH];
    t_entry        r_rd;

    logic          is_stop;
    logic [CW:0]   idx_p1;
    logic [CW:0]   idx_p2;
    logic          full;
    logic          k_lt;
    logic [31:0]   eff_end;
    logic [31:0]   d;
    logic [32:0]   hsum;
    logic          keep;
    logic          live;
    logic          out_free;
    logic          load_out;
    logic          we;
    logic [IW-1:0] waddr;
    logic [IW-1:0] raddr;
    t_entry        wdata;

    assign is_stop = (i_command_type == CMD_STOP);
    assign idx_p1 = {1'b0, r_idx} + {{CW{1'b0}}, 1'b1};
    assign idx_p2 = {1'b0, r_idx} + (CW + 1)'(2);
    assign full = (r_count == CW'(DEPTH));
    assign k_lt = (r_k < KW'(MAX_RESULTS));
    assign eff_end = r_rise ? r_now : r_rd.end_t;
    assign d = eff_end - r_now;
    assign hsum = {d[31], d} + {17'b0, r_hold};
    assign keep = !hsum[32] && (hsum != 33'd0);
    assign live = !d[31] && (d != 32'd0);
    assign out_free = !r_ov || !i_out_stall;
    assign load_out = i_cmd.push || (i_cmd.svc_eval && keep && k_lt && r_pend_v);

    always_comb begin
        o_sts.is_svc = (r_kind == KIND_SERVICE);
        o_sts.estop = r_estop;
        o_sts.over = r_over;
        o_sts.enc = r_enc;
        o_sts.cnt_zero = (r_count == '0);
        o_sts.match = (r_rd.model == r_model) && (r_rd.target == r_target);
        o_sts.idx_last = (idx_p1 >= {1'b0, r_count});
        o_sts.rm_more = (idx_p2 < {1'b0, r_count});
        o_sts.svc_wait = keep && k_lt && r_pend_v && !out_free;
        o_sts.idx_end_next = (idx_p1 == {1'b0, r_count});
        o_sts.pend_v = r_pend_v;
        o_sts.out_free = out_free;
    end

    always_comb begin
        we = 1'b0;
        waddr = r_idx[IW-1:0];
        wdata = {r_model, r_target, r_cmdt, r_inten, r_end};
        raddr = i_cmd.rd_next ? idx_p1[IW-1:0] : r_idx[IW-1:0];
        if (i_cmd.upd) begin
            we = 1'b1;
        end else if (i_cmd.rm_copy) begin
            we = 1'b1;
            wdata = r_rd;
        end else if (i_cmd.resp && r_enc && !full) begin
            we = 1'b1;
            waddr = r_count[IW-1:0];
        end else if (i_cmd.svc_eval && keep) begin
            we = 1'b1;
            waddr = r_w[IW-1:0];
            wdata = r_rd;
            wdata.end_t = eff_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd || i_cmd.rd_next) begin
            r_rd <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= i_kind;
            r_model <= i_model;
            r_target <= i_target_id;
            r_cmdt <= is_stop ? CMD_VIBRATE : i_command_type;
            r_inten <= is_stop ? 8'd0 : i_intensity;
            r_end <= i_now_ms + {16'b0, is_stop ? r_stop : i_duration_ms};
            r_over <= is_stop | i_overwrite;
            r_enc <= i_encodable;
            r_now <= i_now_ms;
            r_estop <= i_estop;
        end
        if (i_cmd.resp_estop || i_cmd.upd || i_cmd.rm_start || i_cmd.resp) begin
            r_p_kind <= RK_STATUS;
            r_p_model <= r_model;
            r_p_target <= r_target;
            r_p_cmd <= r_cmdt;
            r_p_inten <= r_inten;
            if (i_cmd.resp_estop) begin
                r_p_status <= ST_ESTOP;
                r_p_slot <= 4'd0;
            end else if (i_cmd.upd) begin
                r_p_status <= ST_UPDATED;
                r_p_slot <= 4'(r_idx);
            end else if (i_cmd.rm_start) begin
                r_p_status <= ST_UPD_FAIL;
                r_p_slot <= 4'(r_idx);
            end else if (!r_enc) begin
                r_p_status <= ST_UNENC;
                r_p_slot <= 4'd0;
            end else if (full) begin
                r_p_status <= ST_FULL;
                r_p_slot <= 4'd0;
            end else begin
                r_p_status <= ST_ADDED;
                r_p_slot <= 4'(r_count);
            end
        end else if (i_cmd.svc_eval && keep && k_lt) begin
            r_p_kind <= live ? RK_PAYLOAD : RK_TERM;
            r_p_status <= ST_ADDED;
            r_p_slot <= 4'(r_w);
            r_p_model <= r_rd.model;
            r_p_target <= r_rd.target;
            r_p_cmd <= r_rd.cmd;
            r_p_inten <= r_rd.inten;
        end
        if (load_out) begin
            o_result_kind <= r_p_kind;
            o_status <= r_p_status;
            o_slot <= r_p_slot;
            o_slot_model <= r_p_model;
            o_slot_target <= r_p_target;
            o_slot_command <= r_p_cmd;
            o_slot_intensity <= r_p_inten;
            o_last <= i_cmd.push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= HOLD_RESET;
            r_stop <= STOP_RESET;
            r_was_stopped <= 1'b0;
            r_rise <= 1'b0;
            r_count <= '0;
            r_idx <= '0;
            r_w <= '0;
            r_k <= '0;
            r_pend_v <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == CFG_HOLD)) begin
                r_hold <= i_cfg_data;
            end
            if (i_cfg_valid && (i_cfg_index == CFG_STOP)) begin
                r_stop <= i_cfg_data;
            end
            if (i_cmd.latch) begin
                r_idx <= '0;
                r_w <= '0;
                r_k <= '0;
                r_pend_v <= 1'b0;
            end
            if (i_cmd.svc_start) begin
                r_rise <= r_estop && !r_was_stopped;
                r_was_stopped <= r_estop;
            end
            if (i_cmd.idx_inc || i_cmd.rm_copy || i_cmd.svc_eval) begin
                r_idx <= idx_p1[CW-1:0];
            end
            if (i_cmd.resp_estop || i_cmd.upd || i_cmd.rm_start || i_cmd.resp) begin
                r_pend_v <= 1'b1;
            end
            if (i_cmd.resp && r_enc && !full) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.svc_eval && keep) begin
                r_w <= r_w + CW'(1);
                if (k_lt) begin
                    r_k <= r_k + KW'(1);
                    r_pend_v <= 1'b1;
                end
            end
            if (i_cmd.push) begin
                r_pend_v <= 1'b0;
            end
            if (i_cmd.svc_done) begin
                r_count <= r_w;
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("slot count beyond table depth");
    a_write_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w <= r_idx) else $error("compaction write index ahead of scan index");
    a_result_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= KW'(MAX_RESULTS)) else $error("too many results in one round");
    a_count_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |=> (r_count == $past(r_count) - CW'(1)))
        else $error("removal did not shorten the table");
endmodule
`default_nettype wire

// ===== rtl/transmit_slot_scheduler_top.sv =====
// Top level of the transmit slot scheduler.
// One item is taken at a time: a command scans the table slot by slot through
// the slot memory, moving each later slot down when an unencodable update
// removes a slot, and then responds; a service round reads and compacts every
// used slot. Results leave through an output register, and the last result of
// each item carries last. Configuration writes are always ready.
`default_nettype none
module transmit_slot_scheduler_top #(
    parameter int TABLE_DEPTH = tss_pkg::TABLE_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_kind,
    input  wire [2:0]   i_model,
    input  wire [15:0]  i_target_id,
    input  wire [1:0]   i_command_type,
    input  wire [7:0]   i_intensity,
    input  wire [15:0]  i_duration_ms,
    input  wire         i_overwrite,
    input  wire         i_encodable,
    input  wire [31:0]  i_now_ms,
    input  wire         i_estop,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [7:0]   i_cfg_index,
    input  wire [15:0]  i_cfg_data,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [2:0]  o_status,
    output logic [3:0]  o_slot,
    output logic [2:0]  o_slot_model,
    output logic [15:0] o_slot_target,
    output logic [1:0]  o_slot_command,
    output logic [7:0]  o_slot_intensity,
    output logic        o_last
);
    import tss_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    tss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_busy     (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tss_dp #(
        .DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_kind           (i_kind),
        .i_model          (i_model),
        .i_target_id      (i_target_id),
        .i_command_type   (i_command_type),
        .i_intensity      (i_intensity),
        .i_duration_ms    (i_duration_ms),
        .i_overwrite      (i_overwrite),
        .i_encodable      (i_encodable),
        .i_now_ms         (i_now_ms),
        .i_estop          (i_estop),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_result_kind    (o_result_kind),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_slot_model     (o_slot_model),
        .o_slot_target    (o_slot_target),
        .o_slot_command   (o_slot_command),
        .o_slot_intensity (o_slot_intensity),
        .o_last           (o_last)
    );
endmodule
`default_nettype wire
